### hw/rtl/bmpd_pkg.sv
// bmpd_pkg: shared types and constants for the 24-bit bmp pixel decoder
// no dependencies; used by bmpd_core, bmpd_queue and bmp_24bit_pixel_decoder

package bmpd_pkg;

  // default image limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // header layout
  localparam int HDR_BYTES     = 54;
  localparam int FIELD_BYTES   = 4;
  localparam int POS_SIG_B     = 0;
  localparam int POS_SIG_M     = 1;
  localparam int OFS_DATA      = 10;
  localparam int OFS_WIDTH     = 18;
  localparam int OFS_HEIGHT    = 22;
  localparam int OFS_DEPTH     = 28;
  localparam int POS_PIX_FIRST = 30;
  localparam int DEPTH_24      = 24;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  // result field widths
  localparam int COLOUR_W = 8;
  localparam int COORD_W  = 12;

  // output queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SMALL = 3'd1,
    ST_SIG   = 3'd2,
    ST_DEPTH = 3'd3,
    ST_TRUNC = 3'd4,
    ST_SIZE  = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [COLOUR_W-1:0]  red;
    logic [COLOUR_W-1:0]  green;
    logic [COLOUR_W-1:0]  blue;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    status_t              status;
    logic                 last_result;
  } result_t;

  // up to two results per byte: a pixel and the end-of-file status
  typedef struct packed {
    logic [1:0] n_results;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### hw/rtl/bmp_24bit_pixel_decoder.sv
// bmp_24bit_pixel_decoder: top level of the 24-bit uncompressed bmp decoder
// depends on bmpd_pkg, bmpd_core and bmpd_queue
//
// Takes a bmp file one byte per beat, last_byte marking its final byte, and
// gives one beat per decoded pixel (rgb, column, top-down row) and one status
// beat at the end of each file. Each byte sits in the input register, is
// decoded in a single pass against the file state and lands in a four-entry
// result queue, so one byte per cycle is sustained while the output side
// keeps up; the final byte of a file that also completes a pixel gives two
// beats, which the queue absorbs. Pixels stream out before truncation is
// known, so a consumer drops the image when the status is not ok. The
// decoder clears itself after each status beat and the next file may follow
// at once. MAX_WIDTH and MAX_HEIGHT bound the accepted image and size the
// internal counters.

module bmp_24bit_pixel_decoder
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  // byte channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                result_kind,
  output logic [COLOUR_W-1:0] red,
  output logic [COLOUR_W-1:0] green,
  output logic [COLOUR_W-1:0] blue,
  output logic [COORD_W-1:0]  column,
  output logic [COORD_W-1:0]  row,
  output logic [2:0]          status,
  output logic                last_result
);

  // input register
  logic       in_full;
  logic [7:0] byte_r;
  logic       last_r;
  logic       accept;

  // decode and queue
  logic       room;
  logic       go;
  push_t      push;
  result_t    head;

  // a byte is decoded when the queue has space for two results
  assign go       = in_full && room;
  assign in_stall = in_full && !go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= data_byte;
      last_r <= last_byte;
    end
  end

  bmpd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .data_byte (byte_r),
    .last_byte (last_r),
    .push      (push)
  );

  bmpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // result fields straight off the queue head
  assign result_kind = head.kind;
  assign red         = head.red;
  assign green       = head.green;
  assign blue        = head.blue;
  assign column      = head.column;
  assign row         = head.row;
  assign status      = head.status;
  assign last_result = head.last_result;

endmodule

### hw/rtl/bmpd_core.sv
// bmpd_core: header capture, checks, pixel assembly and end-of-file status
// depends on bmpd_pkg

module bmpd_core
  import bmpd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int SW  = $clog2(3 * MAX_WIDTH + 4);
  localparam int PW  = SW + RW;
  localparam int EW  = ((PW > 32) ? PW : 32) + 1;
  localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
  localparam int RXW = (RW > COORD_W) ? RW : COORD_W;

  // file state
  logic [31:0]   pos, pos_next;
  logic [31:0]   start, start_next;
  logic [31:0]   width, width_next;
  logic [31:0]   height, height_next;
  logic [7:0]    depth_lo, depth_lo_next;
  status_t       fault, fault_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] rows, rows_next;
  logic [SW-1:0] rbc, rbc_next;
  logic [7:0]    held_blue, held_blue_next;
  logic [7:0]    held_green, held_green_next;
  logic [1:0]    phase, phase_next;

  // geometry derived from the captured header, tracked every cycle
  logic [SW-1:0] row_bytes;
  logic [SW-1:0] stride;
  logic [31:0]   hm;
  logic [PW-1:0] prod;
  logic [EW-1:0] data_end;

  logic [1:0]     lane_data, lane_width, lane_height;
  logic [15:0]    depth_full;
  logic           size_bad;
  logic           pix_en;
  logic           pix_out;
  logic [SW-1:0]  rbc_inc;
  logic [RW-1:0]  hm_t;
  logic [RW-1:0]  row_val;
  logic [RXW-1:0] row_ext;
  logic [CXW-1:0] col_ext;
  logic [EW-1:0]  total;
  status_t        status_val;
  result_t        pix_res;
  result_t        st_res;

  assign hm_t = hm[RW-1:0];

  always_comb begin
    pos_next        = pos;
    start_next      = start;
    width_next      = width;
    height_next     = height;
    depth_lo_next   = depth_lo;
    fault_next      = fault;
    col_next        = col;
    rows_next       = rows;
    rbc_next        = rbc;
    held_blue_next  = held_blue;
    held_green_next = held_green;
    phase_next      = phase;
    pix_out         = 1'b0;

    lane_data   = 2'(pos - 32'(OFS_DATA));
    lane_width  = 2'(pos - 32'(OFS_WIDTH));
    lane_height = 2'(pos - 32'(OFS_HEIGHT));
    depth_full  = {data_byte, depth_lo};

    // signature
    if (pos == 32'(POS_SIG_B) && data_byte != SIG_B && fault == ST_OK) begin
      fault_next = ST_SIG;
    end
    if (pos == 32'(POS_SIG_M) && data_byte != SIG_M && fault == ST_OK) begin
      fault_next = ST_SIG;
    end

    // little-endian field capture
    if (pos >= 32'(OFS_DATA) && pos < 32'(OFS_DATA + FIELD_BYTES)) begin
      start_next[{lane_data, 3'b000} +: 8] = data_byte;
    end
    if (pos >= 32'(OFS_WIDTH) && pos < 32'(OFS_WIDTH + FIELD_BYTES)) begin
      width_next[{lane_width, 3'b000} +: 8] = data_byte;
    end
    if (pos >= 32'(OFS_HEIGHT) && pos < 32'(OFS_HEIGHT + FIELD_BYTES)) begin
      height_next[{lane_height, 3'b000} +: 8] = data_byte;
    end
    if (pos == 32'(OFS_DEPTH)) begin
      depth_lo_next = data_byte;
    end

    // header checks once the depth field is complete
    size_bad = width[31] || (width > 32'(MAX_WIDTH)) || (hm > 32'(MAX_HEIGHT)) ||
               (start < 32'(HDR_BYTES));
    if (pos == 32'(OFS_DEPTH + 1) && fault == ST_OK) begin
      if (depth_full != 16'(DEPTH_24)) begin
        fault_next = ST_DEPTH;
      end else if (size_bad) begin
        fault_next = ST_SIZE;
      end
    end

    // pixel data
    pix_en  = (pos >= 32'(POS_PIX_FIRST)) && (fault == ST_OK) && (pos >= start) &&
              (width != 32'd0) && (32'(rows) < hm);
    rbc_inc = rbc + SW'(1);
    if (pix_en) begin
      if (rbc < row_bytes) begin
        unique case (phase)
          2'd0: begin
            held_blue_next = data_byte;
            phase_next     = 2'd1;
          end
          2'd1: begin
            held_green_next = data_byte;
            phase_next      = 2'd2;
          end
          default: begin
            pix_out    = 1'b1;
            col_next   = col + CW'(1);
            phase_next = 2'd0;
          end
        endcase
      end
      if (rbc_inc >= stride) begin
        rbc_next   = '0;
        col_next   = '0;
        phase_next = 2'd0;
        rows_next  = rows + RW'(1);
      end else begin
        rbc_next = rbc_inc;
      end
    end

    // saturating byte count
    if (pos != '1) begin
      pos_next = pos + 32'd1;
    end

    // end of file: status, then back to reset state
    total = EW'(pos) + EW'(1);
    if (pos < 32'(HDR_BYTES - 1)) begin
      status_val = ST_SMALL;
    end else if (fault != ST_OK) begin
      status_val = fault;
    end else if (total < data_end) begin
      status_val = ST_TRUNC;
    end else begin
      status_val = ST_OK;
    end

    if (last_byte) begin
      pos_next        = '0;
      start_next      = '0;
      width_next      = '0;
      height_next     = '0;
      depth_lo_next   = '0;
      fault_next      = ST_OK;
      col_next        = '0;
      rows_next       = '0;
      rbc_next        = '0;
      held_blue_next  = '0;
      held_green_next = '0;
      phase_next      = 2'd0;
    end

    // bottom-up files are flipped
    row_val = height[31] ? rows : (hm_t - RW'(1) - rows);
    row_ext = RXW'(row_val);
    col_ext = CXW'(col);

    pix_res             = '0;
    pix_res.kind        = KIND_PIXEL;
    pix_res.red         = data_byte;
    pix_res.green       = held_green;
    pix_res.blue        = held_blue;
    pix_res.column      = col_ext[COORD_W-1:0];
    pix_res.row         = row_ext[COORD_W-1:0];
    pix_res.status      = ST_OK;
    pix_res.last_result = !last_byte;

    st_res             = '0;
    st_res.kind        = KIND_STATUS;
    st_res.status      = status_val;
    st_res.last_result = 1'b1;

    push.n_results = go ? (2'(pix_out) + 2'(last_byte)) : 2'd0;
    push.first     = pix_out ? pix_res : st_res;
    push.second    = st_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      start    <= '0;
      width    <= '0;
      height   <= '0;
      depth_lo <= '0;
      fault    <= ST_OK;
      col      <= '0;
      rows     <= '0;
      rbc      <= '0;
      phase    <= 2'd0;
    end else if (go) begin
      pos      <= pos_next;
      start    <= start_next;
      width    <= width_next;
      height   <= height_next;
      depth_lo <= depth_lo_next;
      fault    <= fault_next;
      col      <= col_next;
      rows     <= rows_next;
      rbc      <= rbc_next;
      phase    <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      held_blue  <= held_blue_next;
      held_green <= held_green_next;
    end
  end

  // geometry pipeline, settles well before the pixel data and file end
  always_ff @(posedge clk) begin
    row_bytes <= {width[SW-2:0], 1'b0} + width[SW-1:0];
    stride    <= (({width[SW-2:0], 1'b0} + width[SW-1:0]) + SW'(3)) & ~SW'(3);
    hm        <= height[31] ? (32'd0 - height) : height;
    prod      <= PW'(stride) * PW'(hm_t);
    data_end  <= EW'(start) + EW'(prod);
  end

endmodule

### hw/rtl/bmpd_queue.sv
// bmpd_queue: small result queue, takes one or two results a cycle, gives one
// while out_stall is low; depends on bmpd_pkg

module bmpd_queue
  import bmpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  result_t         mem [Q_DEPTH];
  logic [Q_AW-1:0] wp, rp;
  logic [Q_CW-1:0] count;
  logic            pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= Q_CW'(Q_DEPTH - 2));
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push.n_results != 2'd0) begin
      mem[wp] <= push.first;
    end
    if (push.n_results == 2'd2) begin
      mem[wp + Q_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + Q_AW'(push.n_results);
      rp    <= rp + Q_AW'(pop);
      count <= count + Q_CW'(push.n_results) - Q_CW'(pop);
    end
  end

endmodule
